/* hw/rtl/si2d_pkg.sv */
// Package for the 2D segment intersection block: types and constants.
// Depends on nothing.
`timescale 1ns / 1ps
package si2d_pkg;
  localparam int unsigned W = 32;
  localparam int unsigned OrShift = 6;
  localparam int unsigned QShift = 9;

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    word_t asx, asy, aex, aey, bsx, bsy, bex, bey;
  } seg_pair_t;

  typedef struct packed {
    logic  hit;
    word_t cross_x;
    word_t cross_y;
    logic  div_fault;
  } result_t;
endpackage

/* hw/rtl/si2d_if.sv */
// Valid/ready channel interface carrying one payload item.
// Depends on si2d_pkg for payload types.
`timescale 1ns / 1ps
interface si2d_in_if;
  logic valid;
  logic ready;
  si2d_pkg::seg_pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface si2d_out_if;
  logic valid;
  logic ready;
  si2d_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/si2d_div.sv */
// Pipelined signed 32-bit truncating divider, one quotient bit per stage.
// Depends on si2d_pkg; stalls with enable.
`timescale 1ns / 1ps
module si2d_div (
  input  logic              clk_i,
  input  logic              en_i,
  input  si2d_pkg::word_t   num_i,
  input  si2d_pkg::word_t   den_i,
  output si2d_pkg::word_t   quo_o
);
  import si2d_pkg::*;
  logic [W-1:0] rem_q [W+1];
  logic [W-1:0] quo_q [W+1];
  logic [W-1:0] dv_q  [W+1];
  logic         neg_q [W+1];
  logic [W-1:0] na, da;

  assign na = num_i[W-1] ? W'(-num_i) : num_i;
  assign da = den_i[W-1] ? W'(-den_i) : den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= na;
      dv_q[0]  <= da;
      neg_q[0] <= num_i[W-1] ^ den_i[W-1];
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_st
    logic [W:0]   trial;
    logic [W:0]   sub;
    assign trial = {rem_q[s], quo_q[s][W-1]};
    assign sub = trial - {1'b0, dv_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[s+1]  <= dv_q[s];
        neg_q[s+1] <= neg_q[s];
        if (!sub[W]) begin
          rem_q[s+1] <= sub[W-1:0];
          quo_q[s+1] <= {quo_q[s][W-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= trial[W-1:0];
          quo_q[s+1] <= {quo_q[s][W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = neg_q[W] ? W'(-quo_q[W]) : quo_q[W];
endmodule

/* hw/rtl/si2d_core.sv */
// Full datapath: tests, slope division, intercepts, crossing division, y.
// Depends on si2d_pkg and si2d_div; advances only while en_i is high.
`timescale 1ns / 1ps
module si2d_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  si2d_pkg::seg_pair_t pair_i,
  output logic                vld_o,
  output si2d_pkg::result_t   res_o
);
  import si2d_pkg::*;
  localparam int unsigned DL = W + 1;

  function automatic word_t smx(word_t a, word_t b);
    return (a > b) ? a : b;
  endfunction
  function automatic word_t smn(word_t a, word_t b);
    return (a < b) ? a : b;
  endfunction

  // stage 1: boxes, differences, shifted factors
  seg_pair_t p1_q;
  logic v1_q, box1_q;
  word_t dax1_q, day1_q, dbx1_q, dby1_q;
  word_t f_q [12];
  logic box_d;
  word_t dax, day, dbx, dby;
  word_t f_d [12];
  always_comb begin
    box_d = !(smx(pair_i.asx, pair_i.aex) < smn(pair_i.bsx, pair_i.bex) ||
              smx(pair_i.bsx, pair_i.bex) < smn(pair_i.asx, pair_i.aex) ||
              smx(pair_i.asy, pair_i.aey) < smn(pair_i.bsy, pair_i.bey) ||
              smx(pair_i.bsy, pair_i.bey) < smn(pair_i.asy, pair_i.aey));
    dax = pair_i.aex - pair_i.asx;
    day = pair_i.aey - pair_i.asy;
    dbx = pair_i.bex - pair_i.bsx;
    dby = pair_i.bey - pair_i.bsy;
    f_d[0]  = (pair_i.bsx - pair_i.asx) >>> OrShift;
    f_d[1]  = (pair_i.bsy - pair_i.asy) >>> OrShift;
    f_d[2]  = (pair_i.bex - pair_i.asx) >>> OrShift;
    f_d[3]  = (pair_i.bey - pair_i.asy) >>> OrShift;
    f_d[4]  = (pair_i.asx - pair_i.bsx) >>> OrShift;
    f_d[5]  = (pair_i.asy - pair_i.bsy) >>> OrShift;
    f_d[6]  = (pair_i.aex - pair_i.bsx) >>> OrShift;
    f_d[7]  = (pair_i.aey - pair_i.bsy) >>> OrShift;
    f_d[8]  = dax >>> OrShift;
    f_d[9]  = day >>> OrShift;
    f_d[10] = dbx >>> OrShift;
    f_d[11] = dby >>> OrShift;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= pair_i; box1_q <= box_d;
      dax1_q <= dax; day1_q <= day; dbx1_q <= dbx; dby1_q <= dby;
      for (int i = 0; i < 12; i++) f_q[i] <= f_d[i];
    end
  end

  // stage 2: eight products
  word_t m2_q [8];
  seg_pair_t p2_q;
  logic v2_q, box2_q;
  word_t dax2_q, day2_q, dbx2_q, dby2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m2_q[0] <= f_q[0] * f_q[9];  m2_q[1] <= f_q[1] * f_q[8];
      m2_q[2] <= f_q[2] * f_q[9];  m2_q[3] <= f_q[3] * f_q[8];
      m2_q[4] <= f_q[4] * f_q[11]; m2_q[5] <= f_q[5] * f_q[10];
      m2_q[6] <= f_q[6] * f_q[11]; m2_q[7] <= f_q[7] * f_q[10];
      p2_q <= p1_q; box2_q <= box1_q;
      dax2_q <= dax1_q; day2_q <= day1_q; dbx2_q <= dbx1_q; dby2_q <= dby1_q;
    end
  end

  // stage 3: decide hit and case, start both slope divisions
  logic hit_d;
  word_t o0, o1, o2, o3;
  always_comb begin
    o0 = m2_q[0] - m2_q[1];
    o1 = m2_q[2] - m2_q[3];
    o2 = m2_q[4] - m2_q[5];
    o3 = m2_q[6] - m2_q[7];
    hit_d = box2_q && !(o0 > 0) && !(o1 < 0) && !(o2 < 0) && !(o3 > 0);
  end

  word_t dna, dda, dnb, ddb, sa, sb;
  assign dna = day2_q <<< QShift;
  assign dda = (dax2_q == '0) ? word_t'(1) : dax2_q;
  assign dnb = dby2_q <<< QShift;
  assign ddb = (dbx2_q == '0) ? word_t'(1) : dbx2_q;
  si2d_div u_div_a (.clk_i, .en_i, .num_i(dna), .den_i(dda), .quo_o(sa));
  si2d_div u_div_b (.clk_i, .en_i, .num_i(dnb), .den_i(ddb), .quo_o(sb));

  // delay line alongside the slope dividers
  logic      dv_q [DL];
  logic      dh_q [DL], dva_q [DL], dvb_q [DL];
  seg_pair_t dp_q [DL];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) dv_q[i] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= v2_q;
      for (int i = 1; i < DL; i++) dv_q[i] <= dv_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dh_q[0] <= hit_d; dp_q[0] <= p2_q;
      dva_q[0] <= (p2_q.asx == p2_q.aex); dvb_q[0] <= (dbx2_q == '0);
      for (int i = 1; i < DL; i++) begin
        dh_q[i] <= dh_q[i-1]; dp_q[i] <= dp_q[i-1];
        dva_q[i] <= dva_q[i-1]; dvb_q[i] <= dvb_q[i-1];
      end
    end
  end

  // stage 4: pick slope, products for intercepts
  logic v4_q, h4_q, va4_q, vb4_q;
  seg_pair_t p4_q;
  word_t s4_q, sb4_q, m4a_q, m4b_q;
  logic v4_d;
  seg_pair_t pd;
  assign v4_d = dv_q[DL-1];
  assign pd = dp_q[DL-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en_i) v4_q <= v4_d;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h4_q <= dh_q[DL-1]; va4_q <= dva_q[DL-1]; vb4_q <= dvb_q[DL-1];
      p4_q <= pd; sb4_q <= sb;
      s4_q <= dva_q[DL-1] ? sb : sa;
      m4a_q <= (dva_q[DL-1] ? sb : sa) * (dva_q[DL-1] ? pd.bsx : pd.asx);
      m4b_q <= sb * pd.bsx;
    end
  end

  // stage 5: intercepts, crossing numerator and denominator
  logic v5_q, h5_q, va5_q, vb5_q;
  seg_pair_t p5_q;
  word_t s5_q, ic5_q, num5_q, den5_q;
  word_t ic_d, icb_d;
  assign ic_d = ((va4_q ? p4_q.bsy : p4_q.asy) <<< QShift) - m4a_q;
  assign icb_d = (p4_q.bsy <<< QShift) - m4b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en_i) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h5_q <= h4_q; va5_q <= va4_q; vb5_q <= vb4_q; p5_q <= p4_q;
      s5_q <= s4_q; ic5_q <= ic_d;
      num5_q <= ic_d - icb_d;
      den5_q <= sb4_q - s4_q;
    end
  end

  word_t cdv, cq;
  assign cdv = (den5_q == '0) ? word_t'(1) : den5_q;
  si2d_div u_div_x (.clk_i, .en_i, .num_i(num5_q), .den_i(cdv), .quo_o(cq));

  logic  ev_q [DL];
  logic  eh_q [DL], ef_q [DL], eu_q [DL];
  word_t ex_q [DL], es_q [DL], ei_q [DL];
  logic  flt_d, usex_d;
  word_t fx_d;
  always_comb begin
    flt_d = va5_q ? vb5_q : (!vb5_q && den5_q == '0);
    usex_d = !va5_q && !vb5_q;
    fx_d = va5_q ? p5_q.asx : p5_q.bsx;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) ev_q[i] <= 1'b0;
    end else if (en_i) begin
      ev_q[0] <= v5_q;
      for (int i = 1; i < DL; i++) ev_q[i] <= ev_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eh_q[0] <= h5_q; ef_q[0] <= flt_d; eu_q[0] <= usex_d;
      ex_q[0] <= fx_d; es_q[0] <= s5_q; ei_q[0] <= ic5_q;
      for (int i = 1; i < DL; i++) begin
        eh_q[i] <= eh_q[i-1]; ef_q[i] <= ef_q[i-1]; eu_q[i] <= eu_q[i-1];
        ex_q[i] <= ex_q[i-1]; es_q[i] <= es_q[i-1]; ei_q[i] <= ei_q[i-1];
      end
    end
  end

  // stage 6: px, product for y
  logic v6_q, h6_q, f6_q;
  word_t x6_q, m6_q, i6_q;
  word_t px_d;
  assign px_d = eu_q[DL-1] ? cq : ex_q[DL-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en_i) v6_q <= ev_q[DL-1];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h6_q <= eh_q[DL-1]; f6_q <= ef_q[DL-1];
      x6_q <= px_d; m6_q <= es_q[DL-1] * px_d; i6_q <= ei_q[DL-1];
    end
  end

  // stage 7: result
  word_t y_d;
  assign y_d = (m6_q + i6_q) >>> QShift;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_o <= 1'b0;
    else if (en_i) vld_o <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.hit <= h6_q;
      res_o.div_fault <= h6_q && f6_q;
      res_o.cross_x <= (h6_q && !f6_q) ? x6_q : '0;
      res_o.cross_y <= (h6_q && !f6_q) ? y_d : '0;
    end
  end
endmodule

/* hw/rtl/segment_intersection_2d_top.sv */
// Top level of the 2D segment intersection block.
// Depends on si2d_pkg, si2d_if and si2d_core.
//
//  channel  | dir | payload
//  in_ch    | in  | eight signed 32-bit endpoint coordinates
//  out_ch   | out | hit, cross_x, cross_y, div_fault
//
// One item per cycle while the output is not stalled; the latency is set by the two chained
// bit-per-stage dividers (slope, then crossing x).
// Reset clears all valid bits; payload registers are not reset.
// A stall at the output freezes the whole pipeline; nothing is lost.
`timescale 1ns / 1ps
module segment_intersection_2d_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  si2d_in_if.sink     in_ch,
  si2d_out_if.source  out_ch
);
  import si2d_pkg::*;
  logic en;
  assign en = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = en;

  si2d_core u_core (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_ch.valid), .pair_i(in_ch.data),
    .vld_o(out_ch.valid), .res_o(out_ch.data)
  );

  a_fault_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.div_fault |-> out_ch.data.hit)
    else $error("fault without hit");
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.div_fault |-> out_ch.data.cross_x == '0)
    else $error("fault point not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped under stall");
endmodule
